@@ hw/rtl/stok_pkg.sv @@
package stok_pkg;

  localparam int PositionBitsDefault = 16;
  localparam int QueueDepthDefault = 4;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_OPER   = 3'd1,
    MODE_NUMBER = 3'd2,
    MODE_IDENT  = 3'd3,
    MODE_STRING = 3'd4,
    MODE_DROP   = 3'd5
  } mode_t;

  localparam logic [4:0] KIND_EQEQ       = 5'd10;
  localparam logic [4:0] KIND_EQ         = 5'd11;
  localparam logic [4:0] KIND_ASSIGN     = 5'd12;
  localparam logic [4:0] KIND_COLON      = 5'd13;
  localparam logic [4:0] KIND_LE         = 5'd14;
  localparam logic [4:0] KIND_LT         = 5'd15;
  localparam logic [4:0] KIND_GE         = 5'd16;
  localparam logic [4:0] KIND_GT         = 5'd17;
  localparam logic [4:0] KIND_KW_IF      = 5'd18;
  localparam logic [4:0] KIND_KW_FN      = 5'd19;
  localparam logic [4:0] KIND_KW_FOR     = 5'd20;
  localparam logic [4:0] KIND_KW_RETURN  = 5'd21;
  localparam logic [4:0] KIND_INTEGER    = 5'd22;
  localparam logic [4:0] KIND_STRING     = 5'd23;
  localparam logic [4:0] KIND_IDENT      = 5'd24;
  localparam logic [4:0] KIND_END        = 5'd25;
  localparam logic [4:0] KIND_BAD_STRING = 5'd26;
  localparam logic [4:0] KIND_BAD_CHAR   = 5'd27;

  // token record, highest field first when packed
  typedef struct packed {
    logic        last;
    logic [15:0] column;
    logic [15:0] line;
    logic [15:0] length;
    logic [15:0] start;
    logic [4:0]  kind;
  } token_t;

  localparam int TokenBits = $bits(token_t);

  // single-char punctuation code, 31 when none
  function automatic logic [4:0] single_code(input logic [7:0] c);
    case (c)
      8'h3b:   single_code = 5'd0;
      8'h29:   single_code = 5'd1;
      8'h28:   single_code = 5'd2;
      8'h7b:   single_code = 5'd3;
      8'h7d:   single_code = 5'd4;
      8'h2c:   single_code = 5'd5;
      8'h2b:   single_code = 5'd6;
      8'h2d:   single_code = 5'd7;
      8'h2a:   single_code = 5'd8;
      8'h2f:   single_code = 5'd9;
      default: single_code = 5'd31;
    endcase
  endfunction

  function automatic logic [4:0] held_kind(input logic [7:0] h, input logic eq);
    case (h)
      8'h3d:   held_kind = eq ? KIND_EQEQ : KIND_EQ;
      8'h3a:   held_kind = eq ? KIND_ASSIGN : KIND_COLON;
      8'h3c:   held_kind = eq ? KIND_LE : KIND_LT;
      default: held_kind = eq ? KIND_GE : KIND_GT;
    endcase
  endfunction

  function automatic logic [15:0] sat16(input logic [15:0] v, input logic [4:0] by);
    logic [16:0] s;
    s = {1'b0, v} + {12'd0, by};
    sat16 = s[16] ? 16'hffff : s[15:0];
  endfunction

endpackage

@@ hw/rtl/stok_front.sv @@
module stok_front import stok_pkg::*; #(
  parameter int PositionBits = PositionBitsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [4:0]   tab_advance,
  input  logic         in_valid,
  input  logic [7:0]   in_byte,
  input  logic         in_eos,
  output logic         in_ready,
  output logic [1:0]   emit_count,
  output token_t [2:0] emit_tok,
  input  logic         space_ok
);

  localparam logic [PositionBits-1:0] PosMax = '1;

  mode_t                   mode, mode_next;
  logic [7:0]              held;
  logic [PositionBits-1:0] pos, ostart, olen;
  logic [15:0]             cline, ccol, oline, ocol;
  logic [47:0]             win;
  logic                    drop;

  logic [7:0]              held_next;
  logic [PositionBits-1:0] pos_next, ostart_next, olen_next;
  logic [15:0]             cline_next, ccol_next, oline_next, ocol_next;
  logic [47:0]             win_next;
  logic                    drop_next;

  function automatic logic [PositionBits-1:0] pinc(input logic [PositionBits-1:0] v);
    pinc = (v == PosMax) ? v : v + 1'b1;
  endfunction

  function automatic logic [15:0] p16(input logic [PositionBits-1:0] v);
    logic [PositionBits+15:0] w;
    w = {16'd0, v};
    p16 = w[15:0];
  endfunction

  assign in_ready = space_ok;
  wire fire = in_valid && in_ready;

  wire c = 1'b0;
  wire is_digit = in_byte >= 8'h30 && in_byte <= 8'h39;
  wire is_alpha = (in_byte >= 8'h61 && in_byte <= 8'h7a) || (in_byte >= 8'h41 && in_byte <= 8'h5a);
  wire is_space = in_byte == 8'h20 || (in_byte >= 8'd9 && in_byte <= 8'd13);
  wire is_oper = in_byte == 8'h3d || in_byte == 8'h3a || in_byte == 8'h3c || in_byte == 8'h3e;

  function automatic logic [4:0] word_kind(input logic [PositionBits-1:0] l,
                                           input logic [47:0] w);
    if (l == 2 && w == 48'h6966) word_kind = KIND_KW_IF;
    else if (l == 2 && w == 48'h666e) word_kind = KIND_KW_FN;
    else if (l == 3 && w == 48'h666f72) word_kind = KIND_KW_FOR;
    else if (l == 6 && w == 48'h72657475726e) word_kind = KIND_KW_RETURN;
    else word_kind = KIND_IDENT;
  endfunction

  token_t [2:0] tk;
  logic [1:0]   n;

  always_comb begin
    logic done;
    logic [4:0] sc;
    token_t t;
    mode_next = mode; held_next = held; pos_next = pos; cline_next = cline;
    ccol_next = ccol; ostart_next = ostart; olen_next = olen; oline_next = oline;
    ocol_next = ocol; win_next = win; drop_next = drop;
    tk = '0; n = 2'd0; done = 1'b0; t = '0;
    sc = single_code(in_byte);

    case (mode)
      MODE_OPER: begin
        t.kind = held_kind(held, in_byte == 8'h3d);
        t.start = p16(ostart); t.line = oline; t.column = ocol;
        t.length = (in_byte == 8'h3d) ? 16'd2 : p16(olen);
        if (in_byte == 8'h3d) begin
          olen_next = PositionBits'(2);
          done = 1'b1;
        end
        tk[n] = t; n = n + 2'd1;
        mode_next = MODE_IDLE;
      end
      MODE_NUMBER: begin
        if (is_digit) begin
          olen_next = pinc(olen); done = 1'b1;
        end else begin
          t.kind = KIND_INTEGER; t.start = p16(ostart); t.length = p16(olen);
          t.line = oline; t.column = ocol;
          tk[n] = t; n = n + 2'd1; mode_next = MODE_IDLE;
        end
      end
      MODE_IDENT: begin
        if (is_digit || is_alpha) begin
          olen_next = pinc(olen); win_next = {win[39:0], in_byte}; done = 1'b1;
        end else begin
          t.kind = word_kind(olen, win); t.start = p16(ostart); t.length = p16(olen);
          t.line = oline; t.column = ocol;
          tk[n] = t; n = n + 2'd1; mode_next = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        if (in_byte == 8'h22) begin
          t.kind = KIND_STRING; t.start = p16(ostart); t.length = p16(olen);
          t.line = oline; t.column = ocol;
          tk[n] = t; n = n + 2'd1; mode_next = MODE_IDLE;
        end else olen_next = pinc(olen);
        done = 1'b1;
      end
      MODE_IDLE: ;
      default: done = 1'b1;
    endcase

    if (!done && !is_space) begin
      t = '0; t.start = p16(pos); t.length = 16'd1; t.line = cline; t.column = ccol;
      if (sc != 5'd31) begin
        t.kind = sc; tk[n] = t; n = n + 2'd1;
      end else if (is_oper) begin
        held_next = in_byte; ostart_next = pos; olen_next = PositionBits'(1);
        oline_next = cline; ocol_next = ccol; mode_next = MODE_OPER;
      end else if (is_digit) begin
        ostart_next = pos; olen_next = PositionBits'(1);
        oline_next = cline; ocol_next = ccol; mode_next = MODE_NUMBER;
      end else if (is_alpha) begin
        ostart_next = pos; olen_next = PositionBits'(1); win_next = {40'd0, in_byte};
        oline_next = cline; ocol_next = ccol; mode_next = MODE_IDENT;
      end else if (in_byte == 8'h22) begin
        ostart_next = pinc(pos); olen_next = '0;
        oline_next = cline; ocol_next = ccol; mode_next = MODE_STRING;
      end else begin
        t.kind = KIND_BAD_CHAR; tk[n] = t; n = n + 2'd1;
        mode_next = MODE_DROP; drop_next = 1'b1;
      end
    end

    if (in_byte == 8'h0a) begin
      cline_next = sat16(cline, 5'd1); ccol_next = 16'd1;
    end else if (in_byte == 8'h09) ccol_next = sat16(ccol, tab_advance);
    else ccol_next = sat16(ccol, 5'd1);
    pos_next = pinc(pos);

    if (in_eos) begin
      t = '0; t.start = p16(ostart_next); t.length = p16(olen_next);
      t.line = oline_next; t.column = ocol_next;
      case (mode_next)
        MODE_OPER: begin t.kind = held_kind(held_next, 1'b0); tk[n] = t; n = n + 2'd1; end
        MODE_NUMBER: begin t.kind = KIND_INTEGER; tk[n] = t; n = n + 2'd1; end
        MODE_IDENT: begin
          t.kind = word_kind(olen_next, win_next); tk[n] = t; n = n + 2'd1;
        end
        MODE_STRING: begin t.kind = KIND_BAD_STRING; tk[n] = t; n = n + 2'd1; end
        default: ;
      endcase
      t = '0; t.kind = KIND_END; t.start = p16(pos_next);
      t.line = cline_next; t.column = ccol_next;
      tk[n] = t; n = n + 2'd1;
      mode_next = MODE_IDLE; held_next = '0; pos_next = '0; cline_next = 16'd1;
      ccol_next = 16'd1; ostart_next = '0; olen_next = '0; oline_next = 16'd1;
      ocol_next = 16'd1; win_next = '0; drop_next = 1'b0;
    end
    if (n != 2'd0) tk[n-2'd1].last = 1'b1;
    tk[0].last = tk[0].last | c;
  end

  assign emit_count = fire ? n : 2'd0;
  assign emit_tok = tk;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE; held <= '0; pos <= '0; cline <= 16'd1; ccol <= 16'd1;
      ostart <= '0; olen <= '0; oline <= 16'd1; ocol <= 16'd1; win <= '0; drop <= 1'b0;
    end else if (fire) begin
      mode <= mode_next; held <= held_next; pos <= pos_next; cline <= cline_next;
      ccol <= ccol_next; ostart <= ostart_next; olen <= olen_next; oline <= oline_next;
      ocol <= ocol_next; win <= win_next; drop <= drop_next;
    end
  end

endmodule

@@ hw/rtl/stok_queue.sv @@
module stok_queue import stok_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic [1:0]   push_count,
  input  token_t [2:0] push_tok,
  output logic         space_ok,
  output logic         out_valid,
  output token_t       out_tok,
  input  logic         out_ready
);

  localparam int Depth = QueueDepthDefault;
  localparam int Aw = $clog2(Depth);

  token_t [Depth-1:0] mem;
  logic [Aw-1:0]      rd, wr;
  logic [Aw:0]        cnt;

  wire pop = out_valid && out_ready;
  assign out_valid = cnt != '0;
  assign out_tok = mem[rd];
  assign space_ok = cnt <= (Aw+1)'(Depth - 3);

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      if (i < push_count) mem[wr + Aw'(i)] <= push_tok[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= '0; wr <= '0; cnt <= '0;
    end else begin
      wr <= wr + Aw'(push_count);
      if (pop) rd <= rd + 1'b1;
      cnt <= cnt + (Aw+1)'(push_count) - (Aw+1)'(pop);
    end
  end

endmodule

@@ hw/rtl/source_tokenizer.sv @@
// Tokens are written into the token queue as the byte that completes them is taken.
// Throughput: one byte per cycle while the four-entry token queue holds at most
// one token; the queue drains one token per cycle while m_tready is high, so a
// byte giving two or three tokens stalls the next byte.
// Reset: synchronous rst returns the scanner to line 1, column 1, offset 0,
// tab_advance to 4, and empties the queue.
module source_tokenizer import stok_pkg::*; #(
  parameter int PositionBits = PositionBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // source_byte
  input  logic        s_tlast,   // end_of_source
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // token_kind, token_start, token_length, token_line,
                                 // token_column, zero fill
  output logic        m_tlast,   // run_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data   // tab_advance
);

  logic [4:0]   tab;
  logic [1:0]   cnt;
  token_t [2:0] tk;
  token_t       ot;
  logic         space_ok;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) tab <= 5'd4;
    else if (cfg_valid) tab <= cfg_data;
  end

  stok_front #(.PositionBits(PositionBits)) u_front (
    .clk, .rst, .tab_advance(tab), .in_valid(s_tvalid), .in_byte(s_tdata),
    .in_eos(s_tlast), .in_ready(s_tready), .emit_count(cnt), .emit_tok(tk),
    .space_ok(space_ok)
  );

  stok_queue u_queue (
    .clk, .rst, .push_count(cnt), .push_tok(tk), .space_ok(space_ok),
    .out_valid(m_tvalid), .out_tok(ot), .out_ready(m_tready)
  );

  assign m_tdata = {3'd0, ot.column, ot.line, ot.length, ot.start, ot.kind};
  assign m_tlast = ot.last;

endmodule

@@ hw/rtl/source_tokenizer_checker.sv @@
module source_tokenizer_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic        m_tlast
);

  ap_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[4:0] <= 5'd27) else $error("bad kind");
  ap_end_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4:0] == 5'd25 |-> m_tlast) else $error("end not last");
  ap_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("drop");
  ap_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid) else $error("valid after reset");

endmodule

bind source_tokenizer source_tokenizer_checker u_chk (.*);

@@ tb/sv/source_tokenizer_checker.sv @@
`timescale 1ns / 1ps

module source_tokenizer_scoreboard import stok_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  output int          fail_count,
  output int          pending,
  output int          token_count
);

  token_t tokens_due[$];

  logic [4:0]  tab_cols;
  mode_t       mode;
  logic [7:0]  held_ch;
  logic [15:0] pos, cur_line, cur_col;
  logic [15:0] tok_start, tok_len, tok_line, tok_col;
  logic [47:0] word_tail;

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [15:0] bump(logic [15:0] v, logic [4:0] by);
    logic [16:0] s;
    s = {1'b0, v} + by;
    return s[16] ? 16'hffff : s[15:0];
  endfunction

  function automatic logic [4:0] pair_kind(logic [7:0] h, bit eq);
    case (h)
      "=":     return eq ? KIND_EQEQ : KIND_EQ;
      ":":     return eq ? KIND_ASSIGN : KIND_COLON;
      "<":     return eq ? KIND_LE : KIND_LT;
      default: return eq ? KIND_GE : KIND_GT;
    endcase
  endfunction

  function automatic logic [4:0] word_kind();
    if (tok_len == 2 && word_tail == 48'h6966) return KIND_KW_IF;
    if (tok_len == 2 && word_tail == 48'h666e) return KIND_KW_FN;
    if (tok_len == 3 && word_tail == 48'h666f72) return KIND_KW_FOR;
    if (tok_len == 6 && word_tail == 48'h72657475726e) return KIND_KW_RETURN;
    return KIND_IDENT;
  endfunction

  task automatic clear_scan();
    mode = MODE_IDLE; held_ch = 0; pos = 0; cur_line = 1; cur_col = 1;
    tok_start = 0; tok_len = 0; tok_line = 1; tok_col = 1; word_tail = 0;
  endtask

  task automatic push_tok(ref token_t q[$], input logic [4:0] k, input logic [15:0] st,
                          input logic [15:0] ln, input logic [15:0] li,
                          input logic [15:0] co);
    token_t t;
    t.kind = k; t.start = st; t.length = ln; t.line = li; t.column = co; t.last = 0;
    q.push_back(t);
  endtask

  task automatic open_tok(logic [15:0] st, logic [15:0] ln);
    tok_start = st; tok_len = ln; tok_line = cur_line; tok_col = cur_col;
  endtask

  task automatic scan_byte(logic [7:0] c, bit eos);
    token_t out[$];
    bit done;
    bit [4:0] sc;
    done = 0;
    case (mode)
      MODE_OPER: begin
        if (c == "=") begin
          push_tok(out, pair_kind(held_ch, 1), tok_start, 2, tok_line, tok_col);
          done = 1;
        end else push_tok(out, pair_kind(held_ch, 0), tok_start, tok_len, tok_line, tok_col);
        mode = MODE_IDLE;
      end
      MODE_NUMBER: begin
        if (is_digit(c)) begin
          tok_len = bump(tok_len, 1); done = 1;
        end else begin
          push_tok(out, KIND_INTEGER, tok_start, tok_len, tok_line, tok_col);
          mode = MODE_IDLE;
        end
      end
      MODE_IDENT: begin
        if (is_digit(c) || is_alpha(c)) begin
          tok_len = bump(tok_len, 1); word_tail = {word_tail[39:0], c}; done = 1;
        end else begin
          push_tok(out, word_kind(), tok_start, tok_len, tok_line, tok_col);
          mode = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        if (c == "\"") begin
          push_tok(out, KIND_STRING, tok_start, tok_len, tok_line, tok_col);
          mode = MODE_IDLE;
        end else tok_len = bump(tok_len, 1);
        done = 1;
      end
      MODE_DROP: done = 1;
      default: ;
    endcase
    if (!done && !(c == " " || (c >= 9 && c <= 13))) begin
      sc = single_code(c);
      if (sc != 5'd31) push_tok(out, sc, pos, 1, cur_line, cur_col);
      else if (c == "=" || c == ":" || c == "<" || c == ">") begin
        held_ch = c; open_tok(pos, 1); mode = MODE_OPER;
      end else if (is_digit(c)) begin
        open_tok(pos, 1); mode = MODE_NUMBER;
      end else if (is_alpha(c)) begin
        open_tok(pos, 1); word_tail = {40'd0, c}; mode = MODE_IDENT;
      end else if (c == "\"") begin
        open_tok(bump(pos, 1), 0); mode = MODE_STRING;
      end else begin
        push_tok(out, KIND_BAD_CHAR, pos, 1, cur_line, cur_col);
        mode = MODE_DROP;
      end
    end
    if (c == 8'h0a) begin
      cur_line = bump(cur_line, 1); cur_col = 1;
    end else if (c == 8'h09) cur_col = bump(cur_col, tab_cols);
    else cur_col = bump(cur_col, 1);
    pos = bump(pos, 1);
    if (eos) begin
      case (mode)
        MODE_OPER:   push_tok(out, pair_kind(held_ch, 0), tok_start, tok_len, tok_line, tok_col);
        MODE_NUMBER: push_tok(out, KIND_INTEGER, tok_start, tok_len, tok_line, tok_col);
        MODE_IDENT:  push_tok(out, word_kind(), tok_start, tok_len, tok_line, tok_col);
        MODE_STRING: push_tok(out, KIND_BAD_STRING, tok_start, tok_len, tok_line, tok_col);
        default: ;
      endcase
      push_tok(out, KIND_END, pos, 0, cur_line, cur_col);
      clear_scan();
    end
    if (out.size() > 0) out[out.size()-1].last = 1;
    foreach (out[i]) tokens_due.push_back(out[i]);
  endtask

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch at %0t token %0d: %s got %0d expected %0d",
             $realtime, token_count, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    token_t got, want;
    if (rst) begin
      tab_cols <= 4;
      clear_scan();
      tokens_due.delete();
      fail_count = 0; token_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) tab_cols <= cfg_data;
      if (s_tvalid && s_tready) scan_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        got = token_t'({m_tlast, m_tdata[68:0]});
        if (tokens_due.size() == 0) begin
          $display("unexpected token at %0t kind %0d", $realtime, got.kind);
          fail_count++;
        end else begin
          want = tokens_due.pop_front();
          if (got.kind != want.kind) report("kind", got.kind, want.kind);
          if (got.start != want.start) report("start", got.start, want.start);
          if (got.length != want.length) report("length", got.length, want.length);
          if (got.line != want.line) report("line", got.line, want.line);
          if (got.column != want.column) report("column", got.column, want.column);
          if (got.last != want.last) report("last", got.last, want.last);
          if (m_tdata[71:69] != 0) report("fill", m_tdata[71:69], 0);
        end
        token_count++;
      end
    end
    pending = tokens_due.size();
  end

endmodule

@@ tb/sv/source_tokenizer_tb.sv @@
`timescale 1ns / 1ps

module source_tokenizer_tb import stok_pkg::*;;

  logic        clk = 0, rst = 1;
  logic        s_tvalid = 0, s_tlast = 0, m_tready = 0, cfg_valid = 0;
  logic [7:0]  s_tdata = 0;
  logic [4:0]  cfg_data = 0;
  logic        s_tready, m_tvalid, m_tlast, cfg_ready;
  logic [71:0] m_tdata;
  int          fail_count, pending, token_count;
  int          byte_count = 0;
  bit          quiet = 0, hold_sink = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  source_tokenizer dut (.*);
  source_tokenizer_scoreboard chk (.*);

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (hold_sink) m_tready <= 0;
    else if (!quiet && $urandom_range(0, 5) == 0) begin
      m_tready <= 0;
      repeat ($urandom_range(1, 12) - 1) @(posedge clk);
    end else m_tready <= 1;
  end

  task automatic send(logic [7:0] b, bit eos);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1; s_tdata <= b; s_tlast <= eos;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    byte_count++;
  endtask

  task automatic send_text(string s, bit eos);
    for (int i = 0; i < s.len(); i++) send(s[i], eos && i == s.len() - 1);
  endtask

  task automatic set_tab(logic [4:0] v);
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1; cfg_data <= v;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 0;
  endtask

  function automatic string pick_piece();
    string p[$] = '{"if", "fn", "for", "return", "iff", "returns", "fo", "x9", "Zz",
                    "==", ":=", "<=", ">=", "=", ":", "<", ">", ";", ")", "(", "{",
                    "}", ",", "+", "-", "*", "/", "0", "12345", "\"ab c\"", "\"\"",
                    " ", "\t", "\n", "\r", "\v", "\f"};
    return p[$urandom_range(0, p.size() - 1)];
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_text("if fn for return x;", 0);
    send_text("()\t{},+-*/", 0);
    send_text("a==b:=c<=d>=e=f:g<h>i", 0);
    send_text("\n123 \"str\"\v\f\r", 1);
    send_text("9", 1);
    send_text("=", 1);
    send_text("\"open", 1);
    send(8'hff, 0);
    send_text("x", 1);
    send(8'h00, 1);
    set_tab(0);
    send_text("\t\ta\t", 1);
    set_tab(16);
    send_text("\tb\n\t(", 1);
    set_tab(31);
    send_text("\t;", 1);
    fork
      begin
        hold_sink = 1;
        repeat (60) @(posedge clk);
        hold_sink = 0;
      end
      send_text("; ; ; ; ; ; ; ; ; ; ; ; ; ; ; ; ; ; ;", 1);
    join
    for (int ph = 0; ph < 4; ph++) begin
      set_tab(ph == 0 ? 5'd1 : 5'($urandom_range(1, 16)));
      while (byte_count < 60 + ph * 75) begin
        if ($urandom_range(0, 19) == 0) begin
          send(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end else send_text(pick_piece(), $urandom_range(0, 25) == 0);
        if ($urandom_range(0, 5) == 0) send(" ", 0);
      end
      send(" ", 1);
    end
    quiet = 1;
    for (int i = 0; i < 30; i++) send(8'h80 | 8'($urandom_range(0, 127)), 0);
    send_text("a", 1);
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("sent %0d bytes and checked %0d tokens", byte_count, token_count);
    $display("covered all token kinds, tab widths 0..31, errors and back-pressure");
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
